@@ src/mru_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mru_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_BITS  = 64;
	localparam int MAX_RES   = 16;
	localparam int OUT_KEY_W = 64;
	localparam int CAP_W     = 5;
	localparam int POS_W     = 4;
	localparam int OP_W      = 2;
	localparam int CAP_MAX   = (DEPTH < MAX_RES) ? DEPTH : MAX_RES;
	localparam int CNT_W     = $clog2(CAP_MAX + 1);
	localparam int ADDR_W    = $clog2(DEPTH);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_USE   = 2'd0,
		OP_CHECK = 2'd1,
		OP_LIST  = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	typedef struct packed {
		logic                 found;
		logic [POS_W-1:0]     position;
		logic                 evicted;
		logic [OUT_KEY_W-1:0] evicted_key;
		logic                 entry_valid;
		logic [OUT_KEY_W-1:0] entry_key;
		logic                 last;
	} res_t;

	// Zero acts as one; larger values saturate at the usable depth.
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] raw);
		logic [CAP_W-1:0] c;
		c = raw;
		if (c == '0) begin
			c = CAP_W'(1);
		end
		if (int'(c) > CAP_MAX) begin
			c = CAP_W'(CAP_MAX);
		end
		return CNT_W'(c);
	endfunction

endpackage

`default_nettype wire

@@ src/mru_recent_list_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake               Moves
// input    in_valid / in_ready     opcode, key
// output   out_valid / out_ready   found, position, evicted, evicted_key,
//                                  entry_valid, entry_key, last
// config   cfg_we                  cfg_wdata (capacity)
//
// One item is in work at a time; the keys sit in a RAM with a registered read.
// A use or check scans one slot per cycle, and a move to the front rewrites
// one slot per cycle.
// A list transfers one entry per cycle when the output is not stalled.
// Reset empties the list and sets capacity to 16; no clearing pass is needed.
// The output register lets the next item be accepted while a result waits.

module mru_recent_list_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [63:0] key,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [3:0]       position,
	output logic             evicted,
	output logic [63:0]      evicted_key,
	output logic             entry_valid,
	output logic [63:0]      entry_key,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata
);

	import mru_pkg::*;

	logic [CAP_W-1:0]    cap_q;
	logic [CNT_W-1:0]    cap;
	logic [CNT_W-1:0]    cfg_cap;
	res_t                res;
	res_t                out_q;
	logic                res_valid;
	logic                res_ready;
	logic                out_valid_q;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [KEY_BITS-1:0] ram_rdata;

	assign cap       = eff_cap(cap_q);
	assign cfg_cap   = eff_cap(cfg_wdata);
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	mru_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.key       (key),
		.cap       (cap),
		.cfg_we    (cfg_we),
		.cfg_cap   (cfg_cap),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	mru_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = out_q.found;
	assign position    = out_q.position;
	assign evicted     = out_q.evicted;
	assign evicted_key = out_q.evicted_key;
	assign entry_valid = out_q.entry_valid;
	assign entry_key   = out_q.entry_key;
	assign last        = out_q.last;

endmodule

`default_nettype wire

@@ src/mru_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mru_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ src/mru_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mru_seq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [mru_pkg::OP_W-1:0]       opcode,
	input  wire logic [63:0]                    key,
	input  wire logic [mru_pkg::CNT_W-1:0]      cap,
	input  wire logic                           cfg_we,
	input  wire logic [mru_pkg::CNT_W-1:0]      cfg_cap,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output mru_pkg::res_t                       res,
	output logic                                ram_we,
	output logic [mru_pkg::ADDR_W-1:0]          ram_waddr,
	output logic [mru_pkg::KEY_BITS-1:0]        ram_wdata,
	output logic [mru_pkg::ADDR_W-1:0]          ram_raddr,
	input  wire logic [mru_pkg::KEY_BITS-1:0]   ram_rdata
);

	import mru_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEARCH = 6'b000010,
		ST_SHIFT  = 6'b000100,
		ST_FRONT  = 6'b001000,
		ST_LIST   = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	op_t                 op_q, op_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	logic [CNT_W-1:0]    idx_q, idx_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    top_w;
	res_t                res_q, res_d;
	res_t                list_res;
	logic                hit;
	logic                at_end;
	logic                full;

	assign hit       = (ram_rdata == key_q);
	assign at_end    = (CNT_W'(idx_q + CNT_W'(1)) == count_q);
	assign full      = (count_q >= cap);
	assign top_w     = full ? CNT_W'(cap - CNT_W'(1)) : count_q;
	assign ram_raddr = ADDR_W'(idx_d);

	always_comb begin
		list_res             = '0;
		list_res.entry_valid = 1'b1;
		list_res.entry_key   = OUT_KEY_W'(ram_rdata);
		list_res.last        = at_end;
	end

	assign res = (state_q == ST_LIST) ? list_res : res_q;

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		key_d     = key_q;
		idx_d     = idx_q;
		count_d   = count_q;
		res_d     = res_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ADDR_W'(CNT_W'(idx_q + CNT_W'(1)));
		ram_wdata = ram_rdata;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				idx_d    = '0;
				if (in_valid) begin
					op_d       = op_t'(opcode);
					key_d      = key[KEY_BITS-1:0];
					res_d      = '0;
					res_d.last = 1'b1;
					case (op_t'(opcode))
						OP_USE: begin
							if (count_q == '0) begin
								count_d = CNT_W'(1);
								state_d = ST_FRONT;
							end else begin
								state_d = ST_SEARCH;
							end
						end
						OP_CHECK: begin
							state_d = (count_q == '0) ? ST_RESULT : ST_SEARCH;
						end
						OP_LIST: begin
							state_d = (count_q == '0) ? ST_RESULT : ST_LIST;
						end
						default: begin
							state_d = ST_RESULT;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					res_d.found    = 1'b1;
					res_d.position = POS_W'(idx_q);
					if (op_q == OP_USE && idx_q != '0) begin
						idx_d   = CNT_W'(idx_q - CNT_W'(1));
						state_d = ST_SHIFT;
					end else begin
						state_d = ST_RESULT;
					end
				end else if (at_end) begin
					if (op_q == OP_USE) begin
						res_d.evicted     = full;
						res_d.evicted_key = full ? OUT_KEY_W'(ram_rdata) : '0;
						count_d           = full ? cap : CNT_W'(count_q + CNT_W'(1));
						if (top_w == '0) begin
							state_d = ST_FRONT;
						end else begin
							idx_d   = CNT_W'(top_w - CNT_W'(1));
							state_d = ST_SHIFT;
						end
					end else begin
						state_d = ST_RESULT;
					end
				end else begin
					idx_d = CNT_W'(idx_q + CNT_W'(1));
				end
			end
			ST_SHIFT: begin
				ram_we = 1'b1;
				if (idx_q == '0) begin
					state_d = ST_FRONT;
				end else begin
					idx_d = CNT_W'(idx_q - CNT_W'(1));
				end
			end
			ST_FRONT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = key_q;
				state_d   = ST_RESULT;
			end
			ST_LIST: begin
				res_valid = 1'b1;
				if (res_ready) begin
					if (at_end) begin
						idx_d   = '0;
						state_d = ST_IDLE;
					end else begin
						idx_d = CNT_W'(idx_q + CNT_W'(1));
					end
				end
			end
			ST_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cfg_we && count_q > cfg_cap) begin
			count_d = cfg_cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		key_q <= key_d;
		res_q <= res_d;
	end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import mru_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = '0;
	logic [63:0] key = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [3:0]  position;
	logic        evicted;
	logic [63:0] evicted_key;
	logic        entry_valid;
	logic [63:0] entry_key;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = 5'd16;

	logic [KEY_BITS-1:0] mru_keys [DEPTH];
	int                  mru_count = 0;
	logic [CAP_W-1:0]    cap_setting = CAP_RESET;
	res_t                pending_results [$];
	logic [63:0]         key_pool [20];
	int                  errors = 0;
	bit                  steady = 1'b0;

	mru_recent_list_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.key         (key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.position    (position),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.entry_valid (entry_valid),
		.entry_key   (entry_key),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 10);
	end

	function automatic int cap_limit();
		int c;
		c = cap_setting;
		if (c == 0) begin
			c = 1;
		end
		if (c > CAP_MAX) begin
			c = CAP_MAX;
		end
		return c;
	endfunction

	function automatic void apply_capacity(logic [CAP_W-1:0] v);
		cap_setting = v;
		if (mru_count > cap_limit()) begin
			mru_count = cap_limit();
		end
	endfunction

	function automatic void mru_predict(op_t op, logic [63:0] k);
		res_t r;
		int   pos;
		int   cap;
		r = '0;
		r.last = 1'b1;
		pos = -1;
		cap = cap_limit();
		for (int i = 0; i < mru_count && pos < 0; i++) begin
			if (mru_keys[i] == k[KEY_BITS-1:0]) begin
				pos = i;
			end
		end
		case (op)
			OP_USE: begin
				if (pos >= 0) begin
					r.found = 1'b1;
					r.position = POS_W'(pos);
					for (int i = pos; i > 0; i--) begin
						mru_keys[i] = mru_keys[i-1];
					end
				end else begin
					if (mru_count >= cap) begin
						r.evicted = 1'b1;
						r.evicted_key = OUT_KEY_W'(mru_keys[cap-1]);
						mru_count = cap - 1;
					end
					for (int i = mru_count; i > 0; i--) begin
						mru_keys[i] = mru_keys[i-1];
					end
					mru_count++;
				end
				mru_keys[0] = k[KEY_BITS-1:0];
				pending_results.push_back(r);
			end
			OP_CHECK: begin
				if (pos >= 0) begin
					r.found = 1'b1;
					r.position = POS_W'(pos);
				end
				pending_results.push_back(r);
			end
			OP_LIST: begin
				if (mru_count == 0) begin
					pending_results.push_back(r);
				end
				for (int i = 0; i < mru_count; i++) begin
					r = '0;
					r.entry_valid = 1'b1;
					r.entry_key = OUT_KEY_W'(mru_keys[i]);
					r.last = (i == mru_count - 1);
					pending_results.push_back(r);
				end
			end
			default: begin
				pending_results.push_back(r);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {found, position, evicted, evicted_key, entry_valid, entry_key, last};
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected transfer at %0t: found=%0d pos=%0d ev=%0d evk=%h valid=%0d key=%h last=%0d",
						$realtime, got.found, got.position, got.evicted, got.evicted_key,
						got.entry_valid, got.entry_key, got.last);
				end
			end else begin
				want = pending_results.pop_front();
				if (got.found !== want.found || got.position !== want.position ||
					got.evicted !== want.evicted || got.evicted_key !== want.evicted_key ||
					got.entry_valid !== want.entry_valid || got.entry_key !== want.entry_key ||
					got.last !== want.last) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch at %0t", $realtime);
						$display("  expected found=%0d pos=%0d ev=%0d evk=%h valid=%0d key=%h last=%0d",
							want.found, want.position, want.evicted, want.evicted_key,
							want.entry_valid, want.entry_key, want.last);
						$display("  actual   found=%0d pos=%0d ev=%0d evk=%h valid=%0d key=%h last=%0d",
							got.found, got.position, got.evicted, got.evicted_key,
							got.entry_valid, got.entry_key, got.last);
					end
				end
			end
		end
	end

	task automatic send_item(op_t op, logic [63:0] k);
		@(negedge clk);
		if (!steady && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key <= k;
		do @(posedge clk); while (!in_ready);
		mru_predict(op, k);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_capacity(v);
	endtask

	function automatic logic [63:0] pick_key();
		if ($urandom_range(0, 99) < 85) begin
			return key_pool[$urandom_range(0, 19)];
		end
		return {$urandom, $urandom};
	endfunction

	task automatic test_empty_list();
		send_item(OP_LIST, {$urandom, $urandom});
		send_item(OP_CHECK, 64'h0);
		send_item(OP_CHECK, '1);
		send_item(OP_RSVD, {$urandom, $urandom});
	endtask

	task automatic test_use_order();
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
		a = 64'h0;
		b = '1;
		c = 64'hA5A5_5A5A_F00F_0FF0;
		d = {$urandom, $urandom};
		send_item(OP_USE, a);
		send_item(OP_USE, b);
		send_item(OP_USE, c);
		send_item(OP_USE, c);
		send_item(OP_USE, a);
		send_item(OP_CHECK, b);
		send_item(OP_CHECK, d);
		send_item(OP_LIST, 64'h0);
		send_item(OP_USE, d);
	endtask

	task automatic test_capacity_cut();
		set_capacity(5'd2);
		send_item(OP_LIST, 64'h0);
		send_item(OP_USE, {$urandom, $urandom});
		send_item(OP_CHECK, 64'h0);
		set_capacity(5'd0);
		send_item(OP_USE, key_pool[2]);
		send_item(OP_USE, key_pool[3]);
		send_item(OP_LIST, 64'h0);
	endtask

	task automatic test_random();
		int          caps [6];
		int          sel;
		op_t         op;
		caps = '{31, 3, 16, 1, 0, 9};
		caps[4] = $urandom_range(0, 31);
		for (int p = 0; p < 6; p++) begin
			set_capacity(CAP_W'(caps[p]));
			steady = (p == 2);
			for (int n = 0; n < 25; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 55) begin
					op = OP_USE;
				end else if (sel < 78) begin
					op = OP_CHECK;
				end else if (sel < 94) begin
					op = OP_LIST;
				end else begin
					op = OP_RSVD;
				end
				send_item(op, pick_key());
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		key_pool[0] = 64'h0;
		key_pool[1] = '1;
		for (int i = 2; i < 20; i++) begin
			key_pool[i] = {$urandom, $urandom};
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_list();
		test_use_order();
		test_capacity_cut();
		test_random();
		wait_idle();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
